### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks. Every check is clocked on clock and
// disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define B64_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### hdl/b64se_pkg.sv
// ---------------------------------------------------------------------------
// Base64 stream encoder package
// Shared constants, types and the alphabet lookup for the encoder.
// ---------------------------------------------------------------------------
package b64se_pkg;

   // Character slots per byte result; one input byte causes at most two characters.
   localparam int MAX_CHARS = 3;

   // Reset value of the line length register.
   localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;

   // Codes for the number of leftover bits carried between bytes.
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_TWO  = 2'd1;
   localparam logic [1:0] PEND_FOUR = 2'd2;

   // ASCII anchors of the alphabet.
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_PLUS    = 7'h2B;
   localparam logic [6:0] CHAR_SLASH   = 7'h2F;

   // Carried encoder state.
   typedef struct packed {
      logic [3:0] pend_bits;
      logic [1:0] pend_code;
      logic [7:0] line_count;
   } enc_state_type;

   // Everything one byte produces: three code slots with line-end marks.
   typedef struct packed {
      logic [MAX_CHARS-1:0][5:0] codes;
      logic [MAX_CHARS-1:0]      ends;
      logic [1:0]                num;
      enc_state_type             next_state;
   } enc_result_type;

   // Maps a 6-bit code to its ASCII character.
   function automatic logic [6:0] b64_ascii(input logic [5:0] code);
      logic [6:0] v;
      v = {1'b0, code};
      if (code < 6'd26) begin
         return CHAR_UPPER_A + v;
      end else if (code < 6'd52) begin
         return v + 7'd71;
      end else if (code < 6'd62) begin
         return v - 7'd4;
      end else if (code == 6'd62) begin
         return CHAR_PLUS;
      end else begin
         return CHAR_SLASH;
      end
   endfunction

endpackage

### hdl/b64se_encode.sv
// ---------------------------------------------------------------------------
// Base64 byte encoder
// Splits one byte plus leftover bits into up to two 6-bit codes, marks
// line ends and computes the next carried state.
// ---------------------------------------------------------------------------
module b64se_encode
   import b64se_pkg::*;
(
   input  enc_state_type  cur_state,
   input  logic [7:0]     line_length,
   input  logic [7:0]     data_byte,
   input  logic           final_byte,
   output enc_result_type result
);

   logic [MAX_CHARS-1:0][5:0] codes;
   logic [1:0]                num;
   logic [1:0]                last_idx;
   logic [3:0]                pend_bits;
   logic [1:0]                pend_code;
   logic [MAX_CHARS-1:0]      ends;
   logic [MAX_CHARS-1:0][7:0] lc_after;
   logic [7:0]                lc_walk;
   logic [8:0]                lc_next;

   // Split the byte against the leftover bits.
   always_comb begin
      codes     = '0;
      num       = 2'd1;
      pend_bits = 4'd0;
      pend_code = PEND_NONE;
      unique case (cur_state.pend_code)
         PEND_NONE: begin
            codes[0]  = data_byte[7:2];
            pend_bits = {2'b00, data_byte[1:0]};
            pend_code = PEND_TWO;
         end
         PEND_TWO: begin
            codes[0]  = {cur_state.pend_bits[1:0], data_byte[7:4]};
            pend_bits = data_byte[3:0];
            pend_code = PEND_FOUR;
         end
         default: begin
            codes[0] = {cur_state.pend_bits[3:0], data_byte[7:6]};
            codes[1] = data_byte[5:0];
            num      = 2'd2;
         end
      endcase

      // On the last byte, flush any leftover bits padded with zeros.
      if (final_byte) begin
         if (pend_code == PEND_TWO) begin
            codes[num] = {pend_bits[1:0], 4'b0000};
            num        = num + 2'd1;
         end else if (pend_code == PEND_FOUR) begin
            codes[num] = {pend_bits[3:0], 2'b00};
            num        = num + 2'd1;
         end
         pend_bits = 4'd0;
         pend_code = PEND_NONE;
      end
   end

   assign last_idx = num - 2'd1;

   // Walk the line counter over each character slot.
   always_comb begin
      lc_walk = cur_state.line_count;
      lc_next = '0;
      for (int i = 0; i < MAX_CHARS; i++) begin
         lc_next     = {1'b0, lc_walk} + 9'd1;
         ends[i]     = (lc_next >= {1'b0, line_length});
         lc_after[i] = ends[i] ? 8'd0 : lc_next[7:0];
         lc_walk     = lc_after[i];
      end
   end

   // Assemble the result; the final byte always closes the line.
   always_comb begin
      result.codes = codes;
      result.num   = num;
      result.ends  = ends;
      if (final_byte) begin
         result.ends[last_idx] = 1'b1;
      end
      result.next_state.pend_bits  = pend_bits;
      result.next_state.pend_code  = pend_code;
      result.next_state.line_count = final_byte ? 8'd0 : lc_after[last_idx];
   end

endmodule

### hdl/base64_stream_encoder.sv
// ---------------------------------------------------------------------------
// Base64 stream encoder
// Encodes a byte stream into base64 characters without padding, with
// line-end marks at a configurable line length.
// ---------------------------------------------------------------------------
// Usage:
//   The req channel takes one byte per transaction, with req_final_byte set
//   on the last byte of a message. The rsp channel gives one character per
//   transaction, with rsp_line_end closing a line and rsp_run_last marking
//   the last character caused by a byte. Each byte gives one or two
//   characters, and a final byte may add one more for its leftover bits, up to two in all.
//   csr_wr_en writes the line length; write it only while the block is idle.
//   A request passes through the hold stage and then the output register
//   before its first character appears. The output port moves one character
//   per cycle while rsp_stall is low; a byte stays in the hold stage until its
//   last character moves out, and the next byte is accepted in that cycle.
//   Reset clears the carried bits, the line counter, both stages, and sets
//   the line length to 76. When rsp_stall is high and rsp_valid is set, the
//   output register holds its character, the hold stage keeps its byte, and req_stall rises.
// ---------------------------------------------------------------------------
module base64_stream_encoder
   import b64se_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_line_end,
   output logic       rsp_run_last,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

`include "assert_macros.svh"

   logic [7:0]                line_length_ff;
   enc_state_type             state_ff;
   enc_result_type            enc_result;

   logic                      hold_valid_ff;
   logic                      hold_valid_in;
   logic [MAX_CHARS-1:0][5:0] hold_codes_ff;
   logic [MAX_CHARS-1:0]      hold_ends_ff;
   logic [1:0]                hold_num_ff;
   logic [1:0]                hold_idx_ff;
   logic [1:0]                hold_idx_in;

   logic                      rsp_valid_ff;
   logic [6:0]                rsp_char_ff;
   logic                      rsp_end_ff;
   logic                      rsp_last_ff;

   logic                      rsp_load;
   logic                      hold_pop;
   logic                      hold_last;
   logic                      req_accept;

   // Handshake control.
   assign rsp_load   = !rsp_valid_ff || !rsp_stall;
   assign hold_pop   = hold_valid_ff && rsp_load;
   assign hold_last  = (hold_idx_ff + 2'd1) == hold_num_ff;
   assign req_stall  = hold_valid_ff && !(hold_pop && hold_last);
   assign req_accept = req_valid && !req_stall;

   // Byte splitting and line tracking.
   b64se_encode u_encode (
      .cur_state   (state_ff),
      .line_length (line_length_ff),
      .data_byte   (req_data_byte),
      .final_byte  (req_final_byte),
      .result      (enc_result)
   );

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_LENGTH_RESET;
      end else if (csr_wr_en) begin
         line_length_ff <= csr_wr_data;
      end
   end

   // Carried state advances once per accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= enc_result.next_state;
      end
   end

   // Hold stage control.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_idx_in   = hold_idx_ff;
      if (hold_pop) begin
         hold_idx_in = hold_idx_ff + 2'd1;
         if (hold_last) begin
            hold_valid_in = 1'b0;
         end
      end
      if (req_accept) begin
         hold_valid_in = 1'b1;
         hold_idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         hold_idx_ff   <= 2'd0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         hold_idx_ff   <= hold_idx_in;
      end
   end

   // Hold stage payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         hold_codes_ff <= enc_result.codes;
         hold_ends_ff  <= enc_result.ends;
         hold_num_ff   <= enc_result.num;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (hold_pop) begin
         rsp_char_ff <= b64_ascii(hold_codes_ff[hold_idx_ff]);
         rsp_end_ff  <= hold_ends_ff[hold_idx_ff];
         rsp_last_ff <= hold_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_line_end = rsp_end_ff;
   assign rsp_run_last = rsp_last_ff;

   // Checks.
   `B64_ASSERT_NEXT(a_accept_fills_hold, req_accept, hold_valid_ff && hold_idx_ff == 2'd0)
   `B64_ASSERT_SAME(a_idx_in_range, hold_valid_ff, hold_idx_ff < hold_num_ff)
   `B64_ASSERT_NEXT(a_final_clears, req_accept && req_final_byte, state_ff.line_count == 8'd0 && state_ff.pend_code == PEND_NONE)
   `B64_ASSERT_NEXT(a_stall_keeps_idx, hold_valid_ff && !rsp_load, $stable(hold_idx_ff))

endmodule
